// File: rtl/rgbcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rgbcf_pkg;
   localparam int MAX_WIDTH_DEF = 2048;
   localparam int CHAN_W = 8;
   localparam int PIX_W = 24;
   localparam int COEF_W = 12;
   localparam int NUM_TAPS = 9;
   localparam int NUM_CHAN = 3;
   localparam int ROW_W = 12;
   localparam int COL_W = 11;
   localparam int SIZE_W = 12;
   localparam int PROD_W = 21;
   localparam int SUM_W = 25;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 60;
   localparam int KLO_W = 60;
   localparam int KHI_W = 48;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KLO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KHI = 2'd3;
   localparam logic [SIZE_W-1:0] WIDTH_RST = 12'd640;
   localparam logic [SIZE_W-1:0] HEIGHT_RST = 12'd480;
   localparam logic [KLO_W-1:0] KLO_RST = 60'h01A01A01A01A01A;
   localparam logic [KHI_W-1:0] KHI_RST = 48'h01A01A01A01A;
   localparam int OUT_DATA_W = 48;

   typedef logic signed [COEF_W-1:0] coef_type [NUM_TAPS];
   typedef logic [CHAN_W-1:0] taps_type [NUM_TAPS];
endpackage
`default_nettype wire

// File: rtl/rgbcf_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module rgbcf_lane (
   input  wire logic                   clock,
   input  wire logic                   adv,
   input  wire rgbcf_pkg::taps_type    taps,
   input  wire rgbcf_pkg::coef_type    coefs,
   output logic [rgbcf_pkg::SUM_W-1:0] sum
);
   import rgbcf_pkg::*;
   logic signed [PROD_W-1:0] prod_ff [NUM_TAPS];
   logic signed [SUM_W-1:0]  acc;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NUM_TAPS; k++)
            prod_ff[k] <= PROD_W'(coefs[k] * $signed({1'b0, taps[k]}));
      end
   end
   always_comb begin
      acc = '0;
      for (int k = 0; k < NUM_TAPS; k++)
         acc = acc + SUM_W'(prod_ff[k]);
   end
   assign sum = acc;
endmodule
`default_nettype wire

// File: rtl/rgbcf_merge.sv
`timescale 1ns / 1ps
`default_nettype none
module rgbcf_merge (
   input  wire logic [rgbcf_pkg::SUM_W-1:0]  sum_b,
   input  wire logic [rgbcf_pkg::SUM_W-1:0]  sum_g,
   input  wire logic [rgbcf_pkg::SUM_W-1:0]  sum_r,
   output logic [rgbcf_pkg::PIX_W-1:0]       pix
);
   import rgbcf_pkg::*;
   function automatic logic [CHAN_W-1:0] clamp(input logic [SUM_W-1:0] s);
      logic signed [SUM_W-9:0] q;
      q = $signed(s[SUM_W-1:8]);
      if (q < 0) return '0;
      else if (q > 255) return 8'hFF;
      else return q[CHAN_W-1:0];
   endfunction
   assign pix = {clamp(sum_r), clamp(sum_g), clamp(sum_b)};
endmodule
`default_nettype wire

// File: rtl/rgb_3x3_convolution_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// 3x3 convolution filter on a raster rgb stream. one pixel per clock sustained while the
// output accepts; three multiplier lanes (one per channel) run over a pipeline (line buffer
// read and window, then products, then sum and clamp), and every pixel yields up to two
// result items (filtered interior pixel one row and column back, then the pixel itself when
// on the border), so the input stalls on pixels causing two items. the result holds row
// and column since items leave out of raster order. no clearing pass after reset.
module rgb_3x3_convolution_filter_core #(
   parameter int MAX_WIDTH = rgbcf_pkg::MAX_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // chan_blue, chan_green, chan_red
   input  wire logic        req_tuser,   // frame_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // out_row, out_col, out_blue, out_green, out_red, pad
   output logic             rsp_tlast,   // last_of_run
   input  wire logic        csr_we,
   input  wire logic [rgbcf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rgbcf_pkg::CSR_DATA_W-1:0] csr_data
);
   import rgbcf_pkg::*;
   localparam int AW = $clog2(MAX_WIDTH);

   logic [SIZE_W-1:0] width_ff, height_ff;
   logic [KLO_W-1:0]  klo_ff;
   logic [KHI_W-1:0]  khi_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RST; height_ff <= HEIGHT_RST;
         klo_ff <= KLO_RST; khi_ff <= KHI_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff <= csr_data[SIZE_W-1:0];
            CSR_HEIGHT: height_ff <= csr_data[SIZE_W-1:0];
            CSR_KLO:    klo_ff <= csr_data[KLO_W-1:0];
            CSR_KHI:    khi_ff <= csr_data[KHI_W-1:0];
            default: ;
         endcase
      end
   end

   logic [13:0] w_eff;
   logic [SIZE_W-1:0] h_eff;
   assign w_eff = (width_ff < 3) ? 14'd3 :
                  (14'(width_ff) > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : 14'(width_ff);
   assign h_eff = (height_ff < 3) ? 12'd3 : height_ff;
   coef_type coefs;
   always_comb begin
      for (int k = 0; k < 5; k++) coefs[k] = $signed(klo_ff[k*COEF_W +: COEF_W]);
      for (int k = 0; k < 4; k++) coefs[k+5] = $signed(khi_ff[k*COEF_W +: COEF_W]);
   end

   // pipeline: s1 (window + address), s2 (products), out register, skid for second item
   logic             adv;
   logic             s1_v_ff, s2_v_ff;
   logic             s1_f_ff, s1_b_ff, s2_f_ff, s2_b_ff;
   logic [ROW_W-1:0] s1_r_ff, s2_r_ff;
   logic [COL_W-1:0] s1_c_ff, s2_c_ff;
   logic [PIX_W-1:0] s1_px_ff, s2_px_ff;
   logic [ROW_W-1:0] row_ff;
   logic [13:0]      col_ff;
   logic [PIX_W-1:0] lb1 [MAX_WIDTH];
   logic [PIX_W-1:0] lb2 [MAX_WIDTH];
   logic [PIX_W-1:0] a1_ff, a2_ff;
   logic [PIX_W-1:0] win_ff [6];
   logic [PIX_W-1:0] wfull [NUM_TAPS];
   logic             wb_ff;
   logic [AW-1:0]    wb_addr_ff;

   // output: item A held in out regs, item B (border) pending
   logic             ov_ff, pend_ff;
   logic [OUT_DATA_W-1:0] od_ff, pd_ff;
   logic             ol_ff;

   logic accept;
   assign accept = req_tvalid && req_tready;

   // position for incoming pixel
   logic [ROW_W-1:0] r_cur, r_nx;
   logic [13:0] c_cur, c_nx;
   always_comb begin
      r_cur = req_tuser ? '0 : row_ff;
      c_cur = req_tuser ? '0 : col_ff;
      if (c_cur >= w_eff) begin c_cur = '0; r_cur = r_cur + 1'b1; end
      if (r_cur >= h_eff) r_cur = '0;
      c_nx = c_cur + 1'b1;
      r_nx = r_cur;
      if (c_nx >= w_eff) begin
         c_nx = '0;
         r_nx = r_cur + 1'b1;
         if (r_nx >= h_eff) r_nx = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0; col_ff <= '0; s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= accept;
         if (accept) begin row_ff <= r_nx; col_ff <= c_nx; end
      end
   end

   // second line is written in the cycle after the read, from the registered first-line data
   logic [AW-1:0] addr;
   assign addr = c_cur[AW-1:0];
   always_ff @(posedge clock) begin
      if (reset) wb_ff <= 1'b0;
      else wb_ff <= adv && accept;
      if (adv && accept) begin
         a1_ff <= lb1[addr];
         a2_ff <= (wb_ff && (wb_addr_ff == addr)) ? a1_ff : lb2[addr];
         lb1[addr] <= req_tdata;
         wb_addr_ff <= addr;
         s1_px_ff <= req_tdata;
         s1_r_ff <= r_cur;
         s1_c_ff <= c_cur[COL_W-1:0];
         s1_f_ff <= (r_cur >= 2) && (c_cur >= 2);
         s1_b_ff <= (r_cur == 0) || (r_cur == h_eff - 1'b1) || (c_cur == 0)
                    || (c_cur == w_eff - 1'b1);
      end
      if (wb_ff) lb2[wb_addr_ff] <= a1_ff;
   end

   always_comb begin
      for (int k = 0; k < 6; k++) wfull[k] = win_ff[k];
      wfull[6] = a2_ff; wfull[7] = a1_ff; wfull[8] = s1_px_ff;
   end

   taps_type tb, tg, tr;
   always_comb begin
      for (int k = 0; k < NUM_TAPS; k++) begin
         tb[k] = wfull[k][7:0]; tg[k] = wfull[k][15:8]; tr[k] = wfull[k][23:16];
      end
   end

   logic adv2;
   assign adv2 = adv && s1_v_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else if (adv) s2_v_ff <= s1_v_ff;
      if (adv2) begin
         for (int k = 0; k < 6; k++) win_ff[k] <= wfull[k+3];
         s2_r_ff <= s1_r_ff; s2_c_ff <= s1_c_ff; s2_px_ff <= s1_px_ff;
         s2_f_ff <= s1_f_ff; s2_b_ff <= s1_b_ff;
      end
   end

   logic [SUM_W-1:0] sb, sg, sr;
   rgbcf_lane u_lb (.clock(clock), .adv(adv2), .taps(tb), .coefs(coefs), .sum(sb));
   rgbcf_lane u_lg (.clock(clock), .adv(adv2), .taps(tg), .coefs(coefs), .sum(sg));
   rgbcf_lane u_lr (.clock(clock), .adv(adv2), .taps(tr), .coefs(coefs), .sum(sr));
   logic [PIX_W-1:0] fpix;
   rgbcf_merge u_mg (.sum_b(sb), .sum_g(sg), .sum_r(sr), .pix(fpix));

   // s2 item may produce two results; out reg must be free and no pending item
   logic out_free;
   assign out_free = !ov_ff || rsp_tready;
   assign adv = out_free && !pend_ff;
   assign req_tready = adv;

   logic [OUT_DATA_W-1:0] fd, bd;
   assign fd = {1'b0, fpix, s2_c_ff - 1'b1, s2_r_ff - 1'b1};
   assign bd = {1'b0, s2_px_ff, s2_c_ff, s2_r_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0; pend_ff <= 1'b0;
      end else if (out_free) begin
         if (pend_ff) begin
            ov_ff <= 1'b1; pend_ff <= 1'b0;
            od_ff <= pd_ff; ol_ff <= 1'b1;
         end else if (s2_v_ff && (s2_f_ff || s2_b_ff)) begin
            ov_ff <= 1'b1;
            od_ff <= s2_f_ff ? fd : bd;
            ol_ff <= !(s2_f_ff && s2_b_ff);
            pend_ff <= s2_f_ff && s2_b_ff;
            pd_ff <= bd;
         end else begin
            ov_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = od_ff;
   assign rsp_tlast = ol_ff;
endmodule
`default_nettype wire

// File: rtl/rgbcf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module rgbcf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic        rsp_tlast
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");
   a_col: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[47] == 1'b0)
      else $error("rsp padding set");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");
   a_nolast: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tlast)
      else $error("second item of run missing");
endmodule
bind rgb_3x3_convolution_filter_core rgbcf_checker u_chk (.*);
`default_nettype wire

// File: verif/rgb_3x3_convolution_filter_core_tb.sv
`timescale 1ns / 1ps
module rgb_3x3_convolution_filter_core_tb;
   import rgbcf_pkg::*;

   localparam int MAXW = MAX_WIDTH_DEF;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [23:0] pixel;
      logic        frame_start;
   } pixel_item_t;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [7:0]       blue;
      logic [7:0]       green;
      logic [7:0]       red;
      logic             last;
   } pixel_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   rgb_3x3_convolution_filter_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // filter model state
   logic [11:0] cfg_width = WIDTH_RST;
   logic [11:0] cfg_height = HEIGHT_RST;
   logic [KLO_W-1:0] cfg_klo = KLO_RST;
   logic [KHI_W-1:0] cfg_khi = KHI_RST;
   logic [23:0] line_mem [2*MAXW];
   logic [23:0] window [9];
   int unsigned row_pos = 0;
   int unsigned col_pos = 0;

   pixel_item_t pending_pixels [$];
   pixel_result_t expected_pixels [$];
   int errors = 0;
   int cycles = 0;
   int items_sent = 0;
   bit hold_request = 0;

   function automatic int coef_at(int k);
      logic signed [COEF_W-1:0] c;
      if (k < 5) c = cfg_klo[12*k +: 12];
      else c = cfg_khi[12*(k-5) +: 12];
      return int'(c);
   endfunction

   function automatic logic [7:0] convolve_channel(int sh);
      int acc;
      int q;
      acc = 0;
      for (int k = 0; k < 9; k++) acc += coef_at(k) * int'(window[k][sh +: 8]);
      q = acc >>> 8;
      if (q < 0) return 8'd0;
      if (q > 255) return 8'd255;
      return q[7:0];
   endfunction

   function automatic void predict_pixel(pixel_item_t it);
      int unsigned w, h, r, c;
      logic [23:0] above1, above2, f;
      pixel_result_t res;
      int n;
      w = cfg_width;
      h = cfg_height;
      if (w < 3) w = 3;
      if (w > MAXW) w = MAXW;
      if (h < 3) h = 3;
      n = 0;
      if (it.frame_start) begin
         row_pos = 0;
         col_pos = 0;
      end
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      r = row_pos;
      c = col_pos;
      above2 = line_mem[MAXW + c];
      above1 = line_mem[c];
      line_mem[MAXW + c] = above1;
      line_mem[c] = it.pixel;
      for (int k = 0; k < 6; k++) window[k] = window[k+3];
      window[6] = above2;
      window[7] = above1;
      window[8] = it.pixel;
      if (r >= 2 && c >= 2) begin
         f = {convolve_channel(16), convolve_channel(8), convolve_channel(0)};
         res = '{row: ROW_W'(r - 1), col: COL_W'(c - 1), blue: f[7:0], green: f[15:8],
                 red: f[23:16], last: 1'b0};
         expected_pixels.push_back(res);
         n++;
      end
      if (r == 0 || r == h - 1 || c == 0 || c == w - 1) begin
         res = '{row: ROW_W'(r), col: COL_W'(c), blue: it.pixel[7:0], green: it.pixel[15:8],
                 red: it.pixel[23:16], last: 1'b0};
         expected_pixels.push_back(res);
         n++;
      end
      if (n > 0) expected_pixels[expected_pixels.size()-1].last = 1'b1;
      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endfunction

   // driver
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_pixel('{pixel: req_tdata, frame_start: req_tuser});
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
               pixel_item_t it;
               it = pending_pixels.pop_front();
               req_tdata <= it.pixel;
               req_tuser <= it.frame_start;
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   int hold_left = 0;
   int mode_left = 0;
   int ready_mode = 0;
   function automatic void check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         errors++;
         $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               errors++;
               $display("%0t unexpected item expected none actual %h last %b", $time,
                        rsp_tdata, rsp_tlast);
            end else begin
               pixel_result_t e;
               e = expected_pixels.pop_front();
               check_field("row", e.row, rsp_tdata[11:0]);
               check_field("col", e.col, rsp_tdata[22:12]);
               check_field("blue", e.blue, rsp_tdata[30:23]);
               check_field("green", e.green, rsp_tdata[38:31]);
               check_field("red", e.red, rsp_tdata[46:39]);
               check_field("last", e.last, rsp_tlast);
            end
         end
         if (hold_request && hold_left == 0) begin
            hold_request = 0;
            hold_left = 300;
         end
         if (mode_left == 0) begin
            mode_left = $urandom_range(10, 80);
            ready_mode = $urandom_range(0, 3);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (ready_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) == 1);
               2: rsp_tready <= ($urandom_range(0, 3) != 0);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      case (idx)
         CSR_WIDTH: cfg_width = val[11:0];
         CSR_HEIGHT: cfg_height = val[11:0];
         CSR_KLO: cfg_klo = val[KLO_W-1:0];
         default: cfg_khi = val[KHI_W-1:0];
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_pixels.size() > 0 || req_tvalid || expected_pixels.size() > 0)
         @(negedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic fill_kernel(logic [11:0] c);
      write_reg(CSR_KLO, {48'h0, c} | {c, 48'h0} | {36'h0, c, 12'h0} | {24'h0, c, 24'h0}
                | {12'h0, c, 36'h0});
      write_reg(CSR_KHI, 60'({c, c, c, c}));
   endtask

   task automatic push_pixel(logic [23:0] px, logic fs);
      pending_pixels.push_back('{pixel: px, frame_start: fs});
      items_sent++;
   endtask

   function automatic logic [7:0] rand_chan();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic push_image(int w, int h, bit noise);
      for (int i = 0; i < w * h; i++)
         push_pixel({rand_chan(), rand_chan(), rand_chan()},
                    (i == 0) || (noise && $urandom_range(0, 40) == 0));
   endtask

   initial begin
      int w, h;
      for (int i = 0; i < 2*MAXW; i++) line_mem[i] = '0;
      for (int i = 0; i < 9; i++) window[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // default size, first row is border only
      push_pixel(24'h000000, 1'b1);
      push_pixel(24'hFFFFFF, 1'b0);
      push_pixel(24'h00FF00, 1'b0);
      push_pixel(24'hFF00FF, 1'b1);
      push_pixel(24'h123456, 1'b0);
      wait_idle();

      // saturating kernels on a bright image
      write_reg(CSR_WIDTH, 60'd3);
      write_reg(CSR_HEIGHT, 60'd3);
      fill_kernel(12'h7FF);
      for (int i = 0; i < 9; i++) push_pixel(24'hFFFFFF, i == 0);
      wait_idle();
      write_reg(CSR_WIDTH, 60'd0);
      write_reg(CSR_HEIGHT, 60'd0);
      fill_kernel(12'h800);
      for (int i = 0; i < 9; i++) push_pixel(24'hFFFFFF, i == 0);
      wait_idle();

      // oversized width clamps to the line store depth
      write_reg(CSR_WIDTH, 60'd4095);
      write_reg(CSR_HEIGHT, 60'd4095);
      for (int i = 0; i < 6; i++) push_pixel({rand_chan(), rand_chan(), rand_chan()}, i == 0);
      wait_idle();

      for (int phase = 0; items_sent < 110; phase++) begin
         w = $urandom_range(3, 9);
         h = $urandom_range(3, 6);
         write_reg(CSR_WIDTH, (phase % 5 == 1) ? 60'($urandom_range(0, 2)) : 60'(w));
         if (phase % 5 == 1) w = 3;
         write_reg(CSR_HEIGHT, 60'(h));
         if (phase % 4 == 3) begin
            write_reg(CSR_KLO, KLO_RST);
            write_reg(CSR_KHI, 60'(KHI_RST));
         end else begin
            write_reg(CSR_KLO, 60'({$urandom, $urandom}));
            write_reg(CSR_KHI, 60'({$urandom, $urandom}));
         end
         if (phase == 0) hold_request = 1;
         for (int n = $urandom_range(1, 3); n > 0; n--) push_image(w, h, phase % 3 == 0);
         wait_idle();
      end

      write_reg(CSR_WIDTH, 60'(WIDTH_RST));
      write_reg(CSR_HEIGHT, 60'(HEIGHT_RST));
      write_reg(CSR_KLO, KLO_RST);
      write_reg(CSR_KHI, 60'(KHI_RST));
      for (int i = 0; i < 4; i++) push_pixel({rand_chan(), rand_chan(), rand_chan()}, i == 0);
      wait_idle();
      repeat (20) @(posedge clock);
      if (errors == 0 && expected_pixels.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
